>>> hw/rtl/tdc_pkg.sv
// package: element type codes, request codes and stage payload types
`default_nettype none
package tdc_pkg;
  typedef enum logic [1:0] {
    ELEM_FP32 = 2'd0,
    ELEM_FP16 = 2'd1,
    ELEM_BF16 = 2'd2,
    ELEM_INT8 = 2'd3
  } elem_t;

  localparam logic REQ_UNPACK = 1'b0;
  localparam logic REQ_PACK   = 1'b1;

  typedef struct packed {
    logic        req_type;
    elem_t       elem_type;
    logic [31:0] raw_in;
  } req_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic [2:0]  elem_bytes;
  } rsp_t;

  // decoded fields carried from the decode stage
  typedef struct packed {
    logic        req_type;
    elem_t       elem_type;
    logic [31:0] raw;
    logic [3:0]  f16_lz;     // leading zeros of the fp16 mantissa field
    logic [2:0]  i8_msb;     // msb position of the int8 magnitude
    logic [7:0]  i8_mag_lo;  // int8 magnitude, low 8 bits
    logic        i8_mag_hi;  // magnitude is 128
  } dec_t;

  function automatic logic [2:0] elem_size(elem_t t);
    logic [2:0] r;
    unique case (t)
      ELEM_FP32: r = 3'd4;
      ELEM_FP16: r = 3'd2;
      ELEM_BF16: r = 3'd2;
      ELEM_INT8: r = 3'd1;
      default:   r = 3'd4;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/tdc_if.sv
// valid/ready stream interface
`default_nettype none
interface tdc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tdc_decode.sv
// stage 1: leading zero counts and int8 magnitude
`default_nettype none
module tdc_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire tdc_pkg::req_t in_req,
  output logic               out_valid,
  output tdc_pkg::dec_t      out_dec
);
  tdc_pkg::dec_t d;
  logic [9:0] m;
  logic [8:0] mag;

  always_comb begin
    m = in_req.raw_in[9:0];
    d.req_type = in_req.req_type;
    d.elem_type = in_req.elem_type;
    d.raw = in_req.raw_in;
    d.f16_lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) d.f16_lz = 4'(9 - i);
    end
    mag = in_req.raw_in[7] ? (9'h100 - {1'b0, in_req.raw_in[7:0]})
                           : {2'b00, in_req.raw_in[6:0]};
    d.i8_mag_lo = mag[7:0];
    d.i8_mag_hi = mag[8] | (in_req.raw_in[7:0] == 8'h80);
    d.i8_msb = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) d.i8_msb = 3'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) out_dec <= d;
  end
endmodule
`default_nettype wire

>>> hw/rtl/tdc_convert.sv
// stage 2: format conversion from decoded fields
`default_nettype none
module tdc_convert (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire tdc_pkg::dec_t in_dec,
  output logic               out_valid,
  output tdc_pkg::rsp_t      out_rsp
);
  logic [31:0] res;
  logic [31:0] r;
  logic [15:0] h;
  logic [9:0]  hm;
  logic [4:0]  hx;
  logic [7:0]  ef;
  logic [22:0] mant;
  logic [23:0] full;
  logic [14:0] f16o;
  logic        sgn;
  logic [8:0]  i8r;
  logic [8:0]  i8m;
  logic [4:0]  sh;
  logic [23:0] q;
  logic [23:0] qh;

  always_comb begin
    r = in_dec.raw;
    h = r[15:0];
    hx = h[14:10];
    hm = h[9:0];
    ef = r[30:23];
    mant = r[22:0];
    sgn = r[31];
    full = {1'b1, mant};
    f16o = '0;
    i8r = '0;
    sh = '0;
    q = '0;
    qh = '0;
    i8m = {in_dec.i8_mag_hi, in_dec.i8_mag_lo};
    res = r;
    if (in_dec.req_type == tdc_pkg::REQ_UNPACK) begin
      unique case (in_dec.elem_type)
        tdc_pkg::ELEM_FP32: res = r;
        tdc_pkg::ELEM_FP16: begin
          if (hx == 5'd0) begin
            if (hm == 10'd0) res = {h[15], 31'd0};
            else res = {h[15], 8'(8'd113 - 8'(in_dec.f16_lz) - 8'd1),
                        10'(hm << (in_dec.f16_lz + 4'd1)), 13'd0};
          end else if (hx == 5'h1F) begin
            res = {h[15], 8'hFF, hm, 13'd0};
          end else begin
            res = {h[15], 8'(hx) + 8'd112, hm, 13'd0};
          end
        end
        tdc_pkg::ELEM_BF16: res = {h, 16'd0};
        tdc_pkg::ELEM_INT8: begin
          if (i8m == 9'd0) res = '0;
          else if (in_dec.i8_mag_hi) res = {1'b1, 8'd134, 23'd0};
          else res = {r[7], 8'd127 + 8'(in_dec.i8_msb),
                      23'({15'd0, in_dec.i8_mag_lo} << (5'd23 - 5'(in_dec.i8_msb)))};
        end
        default: res = r;
      endcase
    end else begin
      unique case (in_dec.elem_type)
        tdc_pkg::ELEM_FP32: res = r;
        tdc_pkg::ELEM_FP16: begin
          // nan keeps only the quiet bit
          if (ef == 8'hFF) f16o = {5'h1F, (mant != 23'd0), 9'd0};
          else if (ef >= 8'd143) f16o = {5'h1F, 10'd0};
          else if (ef <= 8'd112) begin
            // subnormal by right shift, 14 - e with e = ef - 112
            if (ef < 8'd102) f16o = '0;
            else f16o = {5'd0, 10'(full >> (8'd126 - ef))};
          end else f16o = {5'(ef - 8'd112), mant[22:13]};
          res = {16'd0, sgn, f16o};
        end
        tdc_pkg::ELEM_BF16: res = {16'd0, r[31:16]};
        tdc_pkg::ELEM_INT8: begin
          if (ef == 8'hFF && mant != 23'd0) i8r = 9'd0;
          else if (ef > 8'd134) i8r = 9'd200;
          else if (ef < 8'd126) i8r = 9'd0;
          else if (ef == 8'd126) i8r = 9'd1;
          else begin
            sh = 5'(8'd150 - ef);
            q = full >> sh;
            qh = full >> (sh - 5'd1);
            i8r = 9'(q) + 9'(qh[0]);
          end
          if (ef == 8'hFF && mant != 23'd0) res = '0;
          else if (sgn) res = {24'd0, 8'(9'h100 - ((i8r > 9'd128) ? 9'd128 : i8r))};
          else res = {24'd0, (i8r > 9'd127) ? 8'd127 : i8r[7:0]};
        end
        default: res = r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp.result_bits <= res;
      out_rsp.elem_bytes <= tdc_pkg::elem_size(in_dec.elem_type);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/tensor_dtype_converter_core.sv
// top level: tensor element format converter, three register stages
//
// in carries one conversion request per beat (req_type, elem_type, raw_in);
// out carries one result per beat (result_bits, elem_bytes).
// unpack widens fp16, bf16 or int8 to an fp32 pattern; pack narrows fp32
// to the element type; fp32 passes through either way.
// the path from input beat to output valid runs through a decode stage
// with the leading-zero counts, a convert stage, and an output register.
// throughput is one beat per cycle while out does not stall.
// the whole pipeline advances when the output register is empty or taken,
// so a stall on out holds every stage and in.ready falls with out.ready
// whenever the output register holds a beat; nothing is lost or repeated.
// reset clears all valid bits; no item is in flight after reset.
`default_nettype none
module tensor_dtype_converter_core (
  input wire logic clk,
  input wire logic rst,
  tdc_if.sink      in,
  tdc_if.source    out
);
  logic adv;
  logic v1, v2;
  tdc_pkg::dec_t d1;
  tdc_pkg::rsp_t r2;
  tdc_pkg::rsp_t r3;
  logic v3;

  assign adv = !v3 || out.ready;
  assign in.ready = adv;

  tdc_decode u_dec (.clk, .rst, .adv, .in_valid(in.valid), .in_req(in.data),
                    .out_valid(v1), .out_dec(d1));
  tdc_convert u_cvt (.clk, .rst, .adv, .in_valid(v1), .in_dec(d1),
                     .out_valid(v2), .out_rsp(r2));

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (adv) r3 <= r2;
  end

  assign out.valid = v3;
  assign out.data = r3;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("output changed under stall");
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.data.elem_bytes == 3'd1 || out.data.elem_bytes == 3'd2 ||
                  out.data.elem_bytes == 3'd4)
    else $error("bad elem_bytes");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out.valid |-> in.ready)
    else $error("stalled while empty");
endmodule
`default_nettype wire

>>> tb/tdc_tb_if.sv
// testbench-side note: stream interface comes from the rtl; this file holds the tb helper package
`timescale 1ns / 100ps
package tdc_tb_pkg;
  import tdc_pkg::*;

  // exact bit-level predictor of one conversion
  function automatic logic [31:0] widen_fp16(logic [15:0] h);
    logic [31:0] sgn;
    logic [4:0] ex;
    logic [10:0] m;
    logic [7:0] e;
    sgn = {h[15], 31'd0};
    ex = h[14:10];
    m = {1'b0, h[9:0]};
    if (ex == 5'd0) begin
      if (m == 11'd0) return sgn;
      e = 8'd113;
      for (int n = 0; n < 10; n++) begin
        if (m[10]) break;
        m = m << 1;
        e = e - 8'd1;
      end
      return sgn | {1'b0, e, m[9:0], 13'd0};
    end
    if (ex == 5'h1F) return sgn | 32'h7F800000 | {9'd0, m[9:0], 13'd0};
    return sgn | {1'b0, 8'(ex + 8'd112), m[9:0], 13'd0};
  endfunction

  function automatic logic [31:0] widen_int8(logic [7:0] b);
    logic [8:0] mag;
    int p;
    mag = b[7] ? 9'(9'h100 - b) : {1'b0, b};
    if (mag == 0) return 32'd0;
    p = 0;
    while (p < 8 && (mag >> (p + 1)) != 0) p++;
    return {b[7], 8'(127 + p), 23'(({23'd0, mag} << (23 - p)))};
  endfunction

  function automatic logic [15:0] narrow_fp16(logic [31:0] x);
    logic [15:0] sgn;
    int e;
    logic [23:0] m;
    sgn = {x[31], 15'd0};
    e = int'(x[30:23]) - 112;
    m = {1'b0, x[22:0]};
    if (x[30:23] == 8'hFF) return sgn | 16'h7C00 | (x[22:0] != 0 ? 16'h0200 : 16'h0);
    if (e >= 31) return sgn | 16'h7C00;
    if (e <= 0) begin
      if (e < -10) return sgn;
      m[23] = 1'b1;
      return sgn | {6'd0, 10'(m >> (14 - e))};
    end
    return sgn | {1'b0, 5'(e), x[22:13]};
  endfunction

  function automatic logic [7:0] narrow_int8(logic [31:0] x);
    int e;
    int unsigned r, sh;
    logic [23:0] full;
    e = int'(x[30:23]) - 127;
    if (x[30:23] == 8'hFF && x[22:0] != 0) return 8'd0;
    if (e > 7) r = 200;
    else if (e < -1) r = 0;
    else if (e == -1) r = 1;
    else begin
      full = {1'b1, x[22:0]};
      sh = 23 - e;
      r = (full >> sh) + ((full >> (sh - 1)) & 1);
    end
    if (x[31]) begin
      if (r > 128) r = 128;
      return 8'(256 - r);
    end
    if (r > 127) r = 127;
    return 8'(r);
  endfunction

  function automatic rsp_t convert(req_t q);
    rsp_t s;
    s.elem_bytes = (q.elem_type == ELEM_FP32) ? 3'd4 :
                   (q.elem_type == ELEM_INT8) ? 3'd1 : 3'd2;
    if (q.req_type == REQ_UNPACK) begin
      case (q.elem_type)
        ELEM_FP32: s.result_bits = q.raw_in;
        ELEM_FP16: s.result_bits = widen_fp16(q.raw_in[15:0]);
        ELEM_BF16: s.result_bits = {q.raw_in[15:0], 16'd0};
        default:   s.result_bits = widen_int8(q.raw_in[7:0]);
      endcase
    end else begin
      case (q.elem_type)
        ELEM_FP32: s.result_bits = q.raw_in;
        ELEM_FP16: s.result_bits = {16'd0, narrow_fp16(q.raw_in)};
        ELEM_BF16: s.result_bits = {16'd0, q.raw_in[31:16]};
        default:   s.result_bits = {24'd0, narrow_int8(q.raw_in)};
      endcase
    end
    return s;
  endfunction
endpackage

>>> tb/tensor_dtype_converter_core_tb.sv
// testbench: random and directed conversion beats checked against a bit-exact predictor
`timescale 1ns / 100ps
module tensor_dtype_converter_core_tb;
  import tdc_pkg::*;
  import tdc_tb_pkg::*;

  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  tdc_if #(.T(req_t)) req_ch ();
  tdc_if #(.T(rsp_t)) rsp_ch ();

  tensor_dtype_converter_core dut (.clk(clk), .rst(rst), .in(req_ch), .out(rsp_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   n_bad = 0;
  int   n_checked = 0;
  int   cycles = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_cycles = 0;
  bit   hold_done = 1'b0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  // sender: one beat per pending item, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) expected_rsps.push_back(convert(req_ch.data));
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0 || pending_reqs.size() == 0) begin
          req_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          req_ch.valid <= 1'b1;
          req_ch.data <= pending_reqs.pop_front();
          send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
        end
      end
    end
  end

  // one long receiver hold, counted down on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && n_checked >= 150) begin
      hold_cycles <= 60;
      hold_done <= 1'b1;
    end
  end

  // receiver: random stalls, held off while the long hold runs
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_t want;
        if (expected_rsps.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result beat %h", rsp_ch.data);
        end else begin
          want = expected_rsps.pop_front();
          n_checked++;
          if (want.result_bits !== rsp_ch.data.result_bits ||
              want.elem_bytes !== rsp_ch.data.elem_bytes) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp bits %h bytes %0d, got bits %h bytes %0d",
                       want.result_bits, want.elem_bytes,
                       rsp_ch.data.result_bits, rsp_ch.data.elem_bytes);
          end
        end
      end
      if (hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rsp_ch.valid && rsp_ch.ready && $urandom_range(0, 3) == 0)
          recv_gap <= $urandom_range(0, 7);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic req_t mk(logic rq, elem_t t, logic [31:0] r);
    req_t q;
    q.req_type = rq;
    q.elem_type = t;
    q.raw_in = r;
    return q;
  endfunction

  function automatic logic [31:0] rand_f32();
    logic [31:0] x;
    x = $urandom;
    // bias exponent toward the interesting windows
    case ($urandom_range(0, 4))
      0: x[30:23] = 8'(100 + $urandom_range(0, 20));
      1: x[30:23] = 8'(120 + $urandom_range(0, 14));
      2: x[30:23] = 8'(138 + $urandom_range(0, 6));
      3: x[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return x;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [31:0] dir_pack[$];
    logic [15:0] dir_unpack[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and special cases of each conversion
    dir_unpack = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h7C00, 16'hFE01,
                   16'h3C00, 16'h0080, 16'h007F, 16'h0081};
    foreach (dir_unpack[i]) begin
      pending_reqs.push_back(mk(REQ_UNPACK, ELEM_FP16, {16'hFFFF, dir_unpack[i]}));
      pending_reqs.push_back(mk(REQ_UNPACK, ELEM_INT8, {24'hABCDEF, dir_unpack[i][7:0]}));
    end
    pending_reqs.push_back(mk(REQ_UNPACK, ELEM_BF16, 32'h1234FFFF));
    pending_reqs.push_back(mk(REQ_UNPACK, ELEM_FP32, 32'hFFFFFFFF));
    dir_pack = '{32'h7F800000, 32'hFF800001, 32'h477FF000, 32'h47800000, 32'h80000000,
                 32'h387FC000, 32'h33000000, 32'h00000001, 32'h3F000000, 32'hBFC00000,
                 32'h42FF0000, 32'h43000000, 32'hC3000000, 32'hC3010000, 32'h3EFFFFFF};
    foreach (dir_pack[i]) begin
      pending_reqs.push_back(mk(REQ_PACK, ELEM_FP16, dir_pack[i]));
      pending_reqs.push_back(mk(REQ_PACK, ELEM_INT8, dir_pack[i]));
    end
    pending_reqs.push_back(mk(REQ_PACK, ELEM_BF16, 32'hFFC00001));
    pending_reqs.push_back(mk(REQ_PACK, ELEM_FP32, 32'h00000000));

    // sender pause until everything has drained
    wait_drained();

    for (int i = 0; i < 400; i++) begin
      logic rq;
      elem_t t;
      rq = 1'($urandom);
      t = elem_t'($urandom_range(0, 3));
      pending_reqs.push_back(mk(rq, t, rq ? rand_f32() : $urandom));
      if (i % 100 == 99) while (pending_reqs.size() > 10) @(posedge clk);
    end
    wait_drained();
    repeat (10) @(posedge clk);
    $display("ran %0d conversion beats: directed edge cases then random pack/unpack",
             n_checked);
    $display("all element types, with random stalls and one long receiver hold");
    if (n_bad == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
